// File: sv/lps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_pkg
// Shared widths, register codes and the line command record of the line pixel
// stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Coordinate width; the run of one line never exceeds 2^COORD_BITS pixels.
  localparam int COORD_BITS = 6;
  localparam int ACC_W      = 2 * COORD_BITS;
  localparam int RUN_CAP    = 1 << COORD_BITS;
  localparam int CNT_W      = COORD_BITS + 1;

  // Image size registers and colour payload.
  localparam int DIM_W      = 7;
  localparam int COLOUR_W   = 32;
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_t;

  // Command queue between front and back.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Classified line command.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] step_x;   // +1, -1 or 0, modulo 2^COORD_BITS
    logic [COORD_BITS-1:0] step_y;
    logic [COORD_BITS-1:0] inc_x;
    logic [COORD_BITS-1:0] inc_y;
    logic [ACC_W-1:0]      limit;
    logic [COLOUR_W-1:0]   colour;
    logic                  incl;
    logic                  has_line; // 0: start equals end, end point only
  } cmd_t;

endpackage : lps_pkg
`default_nettype wire

// File: sv/lps_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_in_if / lps_out_if
// Valid/ready channels for line commands and for emitted pixels.
// ----------------------------------------------------------------------------
interface lps_in_if import lps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [COLOUR_W-1:0]   pen_colour;
  logic                  include_end;

  modport source (output valid, start_x, start_y, end_x, end_y, pen_colour,
                  include_end, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, pen_colour,
                  include_end, output ready);
endinterface : lps_in_if

interface lps_out_if import lps_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [COLOUR_W-1:0]   pixel_colour;
  logic                  inside_res;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, pixel_colour, inside_res,
                  last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_colour, inside_res,
                  last, output ready);
endinterface : lps_out_if
`default_nettype wire

// File: sv/lps_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_front
// Accepts line commands, derives steps, increments and loop limit, and pushes
// the classified command into the queue. Commands that emit nothing are dropped.
// ----------------------------------------------------------------------------
module lps_front import lps_pkg::*; (
  lps_in_if.sink   in_chan,
  output logic     push_valid,
  output cmd_t     push_data,
  input  logic     push_ready
);

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS-1:0]      abs_dx, abs_dy;
  logic [COORD_BITS-1:0]      inc_x, inc_y;
  logic                       has_line;

  // Deltas and their magnitudes
  always_comb begin
    dx = $signed({1'b0, in_chan.end_x}) - $signed({1'b0, in_chan.start_x});
    dy = $signed({1'b0, in_chan.end_y}) - $signed({1'b0, in_chan.start_y});
    abs_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
  end

  // X accumulator steps by |dy|, y by |dx|; a zero one borrows the other
  always_comb begin
    has_line = (abs_dx != '0) || (abs_dy != '0);
    inc_x    = (abs_dy == '0) ? abs_dx : abs_dy;
    inc_y    = (abs_dx == '0) ? inc_x  : abs_dx;
  end

  // Build the command record
  always_comb begin
    push_data.x        = in_chan.start_x;
    push_data.y        = in_chan.start_y;
    push_data.step_x   = (dx == '0) ? '0 : (dx[COORD_BITS] ? '1 : COORD_BITS'(1));
    push_data.step_y   = (dy == '0) ? '0 : (dy[COORD_BITS] ? '1 : COORD_BITS'(1));
    push_data.inc_x    = inc_x;
    push_data.inc_y    = inc_y;
    push_data.limit    = ACC_W'(inc_x) * ACC_W'(inc_y);
    push_data.colour   = in_chan.pen_colour;
    push_data.incl     = in_chan.include_end;
    push_data.has_line = has_line;
  end

  // Accept whenever the queue has room; drop commands that emit nothing
  assign in_chan.ready = push_ready;
  assign push_valid    = in_chan.valid && (has_line || in_chan.include_end);

endmodule : lps_front
`default_nettype wire

// File: sv/lps_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_fifo
// Short command queue that decouples the front from the pixel stepper.
// ----------------------------------------------------------------------------
module lps_fifo import lps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_data,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_data,
  input  logic pop_ready
);

  cmd_t                 entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign push_ready = (count_r != FIFO_CW'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : lps_fifo
`default_nettype wire

// File: sv/lps_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lps_back
// Pixel stepper: loads one command from the queue, walks the accumulators one
// pixel per cycle while the output is not stalled and emits each pixel
// through an output register.
module lps_back import lps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  input  cmd_t             pop_data,
  output logic             pop_ready,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  lps_out_if.source        out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOP = 3'b010,
    ST_END  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [COORD_BITS-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [ACC_W-1:0]      accx_r, accx_nxt, accy_r, accy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [COORD_BITS-1:0] step_x_r, step_y_r, inc_x_r, inc_y_r;
  logic [ACC_W-1:0]      limit_r;
  logic [COLOUR_W-1:0]   colour_r;
  logic                  incl_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] pixel_x_r, pixel_y_r;
  logic [COLOUR_W-1:0]   pixel_colour_r;
  logic                  inside_r, last_r, last_nxt;

  logic                  advance, emit, load;
  logic                  y_steps, x_steps, cont, cap_hit;
  logic [ACC_W-1:0]      accy_step, accx_step;
  logic [COORD_BITS-1:0] y_step;

  // Output register frees up when empty or being taken
  assign advance   = !out_valid_r || out_chan.ready;
  assign pop_ready = (state_r == ST_IDLE);
  assign load      = pop_valid && pop_ready;
  assign emit      = advance && (state_r inside {ST_LOOP, ST_END});

  // One Bresenham step: y first, then x against the updated y accumulator
  always_comb begin
    y_steps   = (accx_r >= accy_r);
    accy_step = y_steps ? accy_r + ACC_W'(inc_y_r) : accy_r;
    y_step    = y_steps ? y_r + step_y_r : y_r;
    x_steps   = (accx_r <= accy_step);
    accx_step = x_steps ? accx_r + ACC_W'(inc_x_r) : accx_r;
    cont      = (accx_step <= limit_r) && (accy_step <= limit_r);
    cap_hit   = (cnt_r + 1'b1) == CNT_W'(RUN_CAP);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    accx_nxt  = accx_r;
    accy_nxt  = accy_r;
    cnt_nxt   = cnt_r;
    last_nxt  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          x_nxt     = pop_data.x;
          y_nxt     = pop_data.y;
          accx_nxt  = ACC_W'(pop_data.inc_x);
          accy_nxt  = ACC_W'(pop_data.inc_y);
          cnt_nxt   = '0;
          state_nxt = pop_data.has_line ? ST_LOOP : ST_END;
        end
      end
      ST_LOOP: begin
        last_nxt = cap_hit || (!cont && !incl_r);
        if (emit) begin
          x_nxt    = x_r + (x_steps ? step_x_r : '0);
          y_nxt    = y_step;
          accx_nxt = accx_step;
          accy_nxt = accy_step;
          cnt_nxt  = cnt_r + 1'b1;
          if (last_nxt) begin
            state_nxt = ST_IDLE;
          end else if (cont) begin
            state_nxt = ST_LOOP;
          end else begin
            state_nxt = ST_END;
          end
        end
      end
      ST_END: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid tracks emitted and taken pixels
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and command fields
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    accx_r <= accx_nxt;
    accy_r <= accy_nxt;
    cnt_r  <= cnt_nxt;
    if (load) begin
      step_x_r <= pop_data.step_x;
      step_y_r <= pop_data.step_y;
      inc_x_r  <= pop_data.inc_x;
      inc_y_r  <= pop_data.inc_y;
      limit_r  <= pop_data.limit;
      colour_r <= pop_data.colour;
      incl_r   <= pop_data.incl;
    end
  end

  // Capture the emitted pixel with its clip flag
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x_r      <= x_r;
      pixel_y_r      <= y_r;
      pixel_colour_r <= colour_r;
      inside_r       <= (DIM_W'(x_r) < image_width) && (DIM_W'(y_r) < image_height);
      last_r         <= last_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_x      = pixel_x_r;
  assign out_chan.pixel_y      = pixel_y_r;
  assign out_chan.pixel_colour = pixel_colour_r;
  assign out_chan.inside_res   = inside_r;
  assign out_chan.last         = last_r;

  // Run length stays below the cap while stepping
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOP) |-> (cnt_r < CNT_W'(RUN_CAP)))
    else $error("pixel count reached cap inside loop");

  // Both accumulators within the limit while stepping
  a_acc_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOP) |-> (accx_r <= limit_r && accy_r <= limit_r))
    else $error("accumulator beyond limit inside loop");

  // End point is only emitted for inclusive commands
  a_end_incl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_END) |-> incl_r)
    else $error("end point state without include flag");

endmodule : lps_back
`default_nettype wire

// File: sv/line_pixel_stepper_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_pixel_stepper_top
// Line rasterizer: turns line commands into a run of pixel writes.
//
// in_chan carries one line command per transaction (start, end, colour,
// include_end). out_chan carries one pixel per transaction, with an inside
// flag against the configured image size and last on the final pixel.
// Commands whose start equals the end and include_end is 0 produce nothing.
// The cfg port writes image_width (index 0) and image_height (index 1),
// other indexes are ignored; write it only while the block is idle, which
// the block does not enforce. A command passes through the queue into the
// stepper, whose pixels leave through the output register. The stepper
// emits one pixel per cycle while out_chan does not stall; its accumulator
// step is the rate-setting loop. A two-entry command queue lets in_chan
// keep accepting while the stepper works. When out_chan stalls, the pixel
// holds in the output register and the stepper waits. Reset empties the
// queue, drops any pixel in flight and sets the image size to 64 by 64.
// ----------------------------------------------------------------------------
module line_pixel_stepper_top import lps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  lps_in_if.sink               in_chan,
  lps_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  logic             push_valid, push_ready, pop_valid, pop_ready;
  cmd_t             push_data, pop_data;
  logic [DIM_W-1:0] image_width_r, image_height_r;

  // Image size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= DIM_RESET;
      image_height_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lps_front u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  lps_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  lps_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_data     (pop_data),
    .pop_ready    (pop_ready),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .out_chan     (out_chan)
  );

endmodule : line_pixel_stepper_top
`default_nettype wire
